/* sv/tma_pkg.sv */
// Shared constants, types and helpers for the trailing moving average block.
package tma_pkg;

  localparam int MAX_WINDOW  = 1024;
  localparam int SAMPLE_BITS = 32;

  localparam int DATA_W = 32;   // sample and average width on the streams
  localparam int CFG_W  = 11;   // window_length register width
  localparam int AW     = $clog2(MAX_WINDOW);
  localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int CNT_W  = $clog2(SUM_W);

  typedef logic [AW-1:0]           addr_t;
  typedef logic [LEN_W-1:0]        len_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  // Divide request from the window update to the divider
  typedef struct packed {
    logic start;
    sum_t sum;
    len_t len;
  } div_req_t;

  // Divider status toward the control
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

  // Window bookkeeping, exposed for checks
  typedef struct packed {
    len_t len;
    len_t fill;
  } win_status_t;

  // Clamp a written window length to 1..MAX_WINDOW
  function automatic len_t clamp_len(input logic [CFG_W-1:0] value);
    len_t res;
    if (value == '0) begin
      res = len_t'(1);
    end else if (int'(value) > MAX_WINDOW) begin
      res = len_t'(MAX_WINDOW);
    end else begin
      res = len_t'(value);
    end
    return res;
  endfunction

endpackage

/* sv/tma_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module tma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/tma_win.sv */
// Window history memory, running sum, write pointer and fill count.
module tma_win (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [tma_pkg::DATA_W-1:0]   sample,
  input  logic                         first_of_set,
  input  logic                         lookup,
  input  logic                         cfg_we,
  input  logic [tma_pkg::CFG_W-1:0]    cfg_data,
  output tma_pkg::div_req_t            req,
  output tma_pkg::win_status_t         status
);
  import tma_pkg::*;

  logic signed [SAMPLE_BITS-1:0] x;
  logic                          first_q;
  addr_t                         wp;
  len_t                          fill;
  len_t                          len;
  sum_t                          running_sum;

  logic signed [LEN_W:0]         back;
  addr_t                         old_addr;
  logic [SAMPLE_BITS-1:0]        old_raw;
  logic signed [SAMPLE_BITS-1:0] old_s;
  sum_t                          x_ext;
  sum_t                          old_ext;
  sum_t                          base_sum;
  len_t                          base_fill;
  sum_t                          running_sum_next;
  len_t                          fill_next;
  addr_t                         wp_next;

  // Address of the sample that leaves the window, modulo the history depth
  always_comb begin
    back = $signed({1'b0, LEN_W'(wp)}) - $signed({1'b0, len});
    if (back[LEN_W]) begin
      old_addr = AW'(back + (LEN_W + 1)'(MAX_WINDOW));
    end else begin
      old_addr = AW'(back);
    end
  end

  tma_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_WINDOW)
  ) u_hist (
    .clk   (clk),
    .we    (lookup),
    .waddr (wp),
    .wdata (x),
    .re    (accept),
    .raddr (old_addr),
    .rdata (old_raw)
  );

  always_comb begin
    old_s   = $signed(old_raw);
    x_ext   = SUM_W'(x);
    old_ext = SUM_W'(old_s);
    base_sum  = first_q ? '0 : running_sum;
    base_fill = first_q ? '0 : fill;
    if (base_fill >= len) begin
      running_sum_next = base_sum - old_ext + x_ext;
      fill_next        = base_fill;
    end else begin
      running_sum_next = base_sum + x_ext;
      fill_next        = base_fill + len_t'(1);
    end
    wp_next = (int'(wp) == MAX_WINDOW - 1) ? '0 : wp + addr_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp          <= '0;
      fill        <= '0;
      len         <= len_t'(1);
      running_sum <= '0;
    end else if (cfg_we) begin
      len         <= clamp_len(cfg_data);
      fill        <= '0;
      running_sum <= '0;
    end else if (lookup) begin
      wp          <= wp_next;
      fill        <= fill_next;
      running_sum <= running_sum_next;
    end
  end

  // Hold the sample and its flag until the history read returns
  always_ff @(posedge clk) begin
    if (accept) begin
      x       <= $signed(sample[SAMPLE_BITS-1:0]);
      first_q <= first_of_set;
    end
  end

  assign req.start   = lookup;
  assign req.sum     = running_sum_next;
  assign req.len     = len;
  assign status.len  = len;
  assign status.fill = fill;

endmodule

/* sv/tma_div.sv */
// Restoring divider, one quotient bit per cycle, truncating toward zero.
module tma_div (
  input  logic              clk,
  input  logic              rst,
  input  tma_pkg::div_req_t req,
  input  logic              ack,
  output tma_pkg::div_rsp_t rsp
);
  import tma_pkg::*;

  logic              busy;
  logic              done;
  logic              neg;
  logic [CNT_W-1:0]  cnt;
  logic [SUM_W-1:0]  quo;
  logic [LEN_W-1:0]  rem;
  len_t              dvs;

  logic [LEN_W:0]    trial;
  logic              fits;
  logic [LEN_W-1:0]  rem_next;
  logic [DATA_W-1:0] mag;

  always_comb begin
    trial    = {rem, quo[SUM_W-1]};
    fits     = trial >= {1'b0, dvs};
    rem_next = fits ? LEN_W'(trial - {1'b0, dvs}) : LEN_W'(trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      if (int'(cnt) == SUM_W - 1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else if (ack) begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg <= req.sum[SUM_W-1];
      quo <= req.sum[SUM_W-1] ? SUM_W'(-req.sum) : SUM_W'(req.sum);
      rem <= '0;
      dvs <= req.len;
      cnt <= '0;
    end else if (busy) begin
      quo <= {quo[SUM_W-2:0], fits};
      rem <= rem_next;
      cnt <= cnt + CNT_W'(1);
    end
  end

  assign mag          = quo[DATA_W-1:0];
  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = neg ? DATA_W'(-mag) : mag;

endmodule

/* sv/trailing_moving_average.sv */
// Top level of the trailing boxcar moving average.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------
//  s_      | in        | s_tvalid / s_tready | tdata = sample, tuser = first_of_set
//  m_      | out       | m_tvalid / m_tready | tdata = average
//  cfg_    | in        | cfg_valid/cfg_ready | cfg_data = window_length
//
// One sample at a time: no new beat is taken until the last quotient is handed
// off. The accept cycle reads the leaving sample from the history memory, the
// lookup state updates the running sum and writes the new sample, the bit-serial
// divider takes one bit of the 42-bit sum per cycle, and the handoff moves the
// quotient into the output register, which frees the input side, so a stalled
// m_tready only holds the flow once the next quotient is ready.
// Reset clears the running sum, fill count and write pointer and sets the
// window length to 1; the history memory is not cleared, and the fill
// count keeps every read within samples written in the current set.
module trailing_moving_average (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [tma_pkg::DATA_W-1:0] s_tdata,   // [31:0] sample
  input  logic                       s_tuser,   // [0] first_of_set
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [tma_pkg::DATA_W-1:0] m_tdata,   // [31:0] average
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [tma_pkg::CFG_W-1:0]  cfg_data
);
  import tma_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_DIVIDE
  } state_t;

  state_t      state;
  logic        accept;
  logic        lookup;
  logic        cfg_we;
  logic        handoff;
  div_req_t    req;
  div_rsp_t    rsp;
  win_status_t status;

  // Take a beat or a register write only between samples
  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign lookup    = (state == S_LOOKUP);
  // Move the quotient once the output register is empty or being drained
  assign handoff   = (state == S_DIVIDE) && rsp.done && (!m_tvalid || m_tready);

  tma_win u_win (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .sample       (s_tdata),
    .first_of_set (s_tuser),
    .lookup       (lookup),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .req          (req),
    .status       (status)
  );

  tma_div u_div (
    .clk (clk),
    .rst (rst),
    .req (req),
    .ack (handoff),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          state <= S_DIVIDE;
        end
        S_DIVIDE: begin
          if (handoff) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // Drop the result beat once taken, unless a new one replaces it
      if (handoff) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (handoff) begin
      m_tdata <= rsp.quotient;
    end
  end

`ifndef SYNTHESIS
  // Divider is quiet whenever a new beat can be taken
  a_idle_div_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!rsp.busy && !rsp.done))
    else $error("divider active while idle");

  // Fill count never passes the window length
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    status.fill <= status.len)
    else $error("fill count above window length");

  // Window length stays within 1..MAX_WINDOW
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    (status.len != '0) && (int'(status.len) <= MAX_WINDOW))
    else $error("window length out of range");

  // The lookup cycle always starts the divider
  a_lookup_starts: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOKUP) |=> rsp.busy)
    else $error("divider not started after lookup");
`endif

endmodule
